// ===== rtl/tsbrf_pkg.sv =====
`default_nettype none

package tsbrf_pkg;

  // field widths fixed by the item formats
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned SCALE_W = 10;
  localparam int unsigned CFG_W   = 10;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FAIL = 1'b1
  } status_e;

  typedef enum logic {
    CFG_CAPTURE_ENABLE = 1'b0,
    CFG_TICK_SCALE     = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_STAMP,
    ST_WRITE,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  // one FIFO entry: data byte and its timestamp
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/tsbrf_mem.sv =====
`default_nettype none

module tsbrf_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire tsbrf_pkg::entry_t   wdata_i,
  input  wire logic                re_i,
  input  wire logic [AW-1:0]       raddr_i,
  output tsbrf_pkg::entry_t        rdata_o
);

  tsbrf_pkg::entry_t mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/timestamped_byte_ring_fifo_top.sv =====
// Circular receive FIFO of timestamped bytes. A push (tuser op = 0) offers a
// packet of up to PACKET_BYTES bytes that is stored whole or refused whole; each
// stored byte carries now_ticks * tick_scale truncated to 32 bits. A pull
// (tuser op = 1) returns the oldest byte with its timestamp. Every input
// transaction yields exactly one result transaction; tuser of the result is
// the status (1 = refused push or empty pull). One slot stays unused, so at
// most FIFO_DEPTH-1 bytes are held. Items are handled one at a time by a small
// sequencer around a single-port write / single-port read memory: a refused
// push, an empty packet or an empty pull passes CHECK then DONE, a pull adds
// READ_WAIT and an accepted push STAMP and one WRITE per byte, the write port
// taking one byte per cycle; a full output register holds the sequencer in
// DONE. The next item is taken while a result still waits at the output
// register. No clearing pass after reset; entries are only read once written.
`default_nettype none

module timestamped_byte_ring_fifo_top #(
  parameter int unsigned FIFO_DEPTH   = 1024,
  parameter int unsigned PACKET_BYTES = 4
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // configuration
  input  wire logic                                 cfg_we_i,
  input  wire logic                                 cfg_idx_i,
  input  wire logic [tsbrf_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // byte_count[2:0], byte_first[10:3], byte_second[18:11], byte_third[26:19],
  // byte_fourth[34:27], now_ticks[66:35], zero[71:67]
  input  wire logic [tsbrf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // op[0]
  input  wire logic                                 s_axis_tuser,
  // result stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // out_byte[7:0], out_time[39:8], overflow_flag[40], zero[47:41]
  output logic [tsbrf_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
  // status[0]
  output logic                                      m_axis_tuser
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned BW = tsbrf_pkg::BYTE_W;
  localparam int unsigned TW = tsbrf_pkg::TIME_W;
  localparam int unsigned NW = tsbrf_pkg::COUNT_W;

  // ---------------------------------------------------------------- registers
  tsbrf_pkg::state_e state_q, state_d;

  logic                              cap_en_q;
  logic [tsbrf_pkg::SCALE_W-1:0]     scale_q;

  logic [PW-1:0]  wp_q, rp_q;
  logic           same_lap_q;
  logic           ovf_q;

  tsbrf_pkg::op_e op_q;
  logic [NW-1:0]  n_q;
  logic [BW-1:0]  pkt_q [4];
  logic [TW-1:0]  ticks_q;
  logic [TW-1:0]  stamp_q;
  logic [NW-1:0]  cnt_q;

  tsbrf_pkg::status_e res_status_q;
  logic [BW-1:0]      res_byte_q;
  logic [TW-1:0]      res_time_q;

  logic                m_valid_q;
  tsbrf_pkg::status_e  m_status_q;
  logic [BW-1:0]       m_byte_q;
  logic [TW-1:0]       m_time_q;
  logic                m_ovf_q;

  // ------------------------------------------------------------ input decode
  logic          s_fire;
  logic [NW-1:0] in_count, in_n;

  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign in_count = s_axis_tdata[NW-1:0];

  always_comb begin
    if (32'(in_count) > PACKET_BYTES) begin
      in_n = NW'(PACKET_BYTES);
    end else begin
      in_n = in_count;
    end
  end

  // ------------------------------------------- shared pointer step and checks
  logic [PW-1:0] step_in, step_out;
  logic          step_wrap;

  assign step_in   = (state_q == tsbrf_pkg::ST_WRITE) ? wp_q : rp_q;
  assign step_wrap = (step_in == PW'(FIFO_DEPTH - 1));
  assign step_out  = step_wrap ? '0 : step_in + PW'(1);

  logic [PW:0] fit_sum, fit_over;
  logic        fits, empty;

  assign fit_sum  = {1'b0, wp_q} + (PW+1)'(n_q);
  assign fit_over = fit_sum - (PW+1)'(FIFO_DEPTH);

  always_comb begin
    if (fit_sum >= (PW+1)'(FIFO_DEPTH)) begin
      fits = same_lap_q && (fit_over < {1'b0, rp_q});
    end else begin
      fits = same_lap_q || (fit_sum < {1'b0, rp_q});
    end
  end

  assign empty = same_lap_q && (rp_q >= wp_q);

  // one 32x10 multiply, registered in ST_STAMP
  logic [TW+tsbrf_pkg::SCALE_W-1:0] prod;
  assign prod = ticks_q * scale_q;

  logic          out_free;
  assign out_free = !m_valid_q || m_axis_tready;

  logic          last_byte;
  assign last_byte = (cnt_q + NW'(1) == n_q);

  // ---------------------------------------------------------------- memory
  logic               mem_we, mem_re;
  tsbrf_pkg::entry_t  mem_wdata, mem_rdata;

  always_comb begin
    mem_wdata.stamp = stamp_q;
    if (cnt_q < NW'(4)) begin
      mem_wdata.data = pkt_q[cnt_q[1:0]];
    end else begin
      mem_wdata.data = '0;
    end
  end

  tsbrf_mem #(
    .DEPTH (FIFO_DEPTH),
    .AW    (PW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rp_q),
    .rdata_o (mem_rdata)
  );

  // ------------------------------------------------------------- next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsbrf_pkg::ST_IDLE: begin
        if (s_fire) state_d = tsbrf_pkg::ST_CHECK;
      end
      tsbrf_pkg::ST_CHECK: begin
        if (op_q == tsbrf_pkg::OP_PULL) begin
          state_d = empty ? tsbrf_pkg::ST_DONE : tsbrf_pkg::ST_READ_WAIT;
        end else if (cap_en_q && fits && (n_q != '0)) begin
          state_d = tsbrf_pkg::ST_STAMP;
        end else begin
          state_d = tsbrf_pkg::ST_DONE;
        end
      end
      tsbrf_pkg::ST_STAMP:     state_d = tsbrf_pkg::ST_WRITE;
      tsbrf_pkg::ST_WRITE: begin
        if (last_byte) state_d = tsbrf_pkg::ST_DONE;
      end
      tsbrf_pkg::ST_READ_WAIT: state_d = tsbrf_pkg::ST_DONE;
      tsbrf_pkg::ST_DONE: begin
        if (out_free) state_d = tsbrf_pkg::ST_IDLE;
      end
      default:                 state_d = tsbrf_pkg::ST_IDLE;
    endcase
  end

  // ----------------------------------------------------------------- outputs
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    unique case (state_q)
      tsbrf_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      tsbrf_pkg::ST_CHECK: mem_re = (op_q == tsbrf_pkg::OP_PULL) && !empty;
      tsbrf_pkg::ST_WRITE: mem_we = 1'b1;
      tsbrf_pkg::ST_STAMP,
      tsbrf_pkg::ST_READ_WAIT,
      tsbrf_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  // ---------------------------------------------------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tsbrf_pkg::ST_IDLE;
      cap_en_q   <= 1'b1;
      scale_q    <= tsbrf_pkg::SCALE_W'(1);
      wp_q       <= '0;
      rp_q       <= '0;
      same_lap_q <= 1'b1;
      ovf_q      <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (tsbrf_pkg::cfg_idx_e'(cfg_idx_i))
          tsbrf_pkg::CFG_CAPTURE_ENABLE: cap_en_q <= cfg_wdata_i[0];
          tsbrf_pkg::CFG_TICK_SCALE:     scale_q  <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (state_q == tsbrf_pkg::ST_CHECK) begin
        if (op_q == tsbrf_pkg::OP_PULL) begin
          if (!empty) begin
            rp_q <= step_out;
            if (step_wrap) same_lap_q <= 1'b1;
          end
        end else if (cap_en_q) begin
          ovf_q <= !fits;
        end
      end

      if (state_q == tsbrf_pkg::ST_WRITE) begin
        wp_q <= step_out;
        if (step_wrap) same_lap_q <= 1'b0;
      end

      if (state_q == tsbrf_pkg::ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ payload regs
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q     <= tsbrf_pkg::op_e'(s_axis_tuser);
      n_q      <= in_n;
      pkt_q[0] <= s_axis_tdata[10:3];
      pkt_q[1] <= s_axis_tdata[18:11];
      pkt_q[2] <= s_axis_tdata[26:19];
      pkt_q[3] <= s_axis_tdata[34:27];
      ticks_q  <= s_axis_tdata[66:35];
    end

    unique case (state_q)
      tsbrf_pkg::ST_CHECK: begin
        res_byte_q <= '0;
        res_time_q <= '0;
        if (op_q == tsbrf_pkg::OP_PULL) begin
          res_status_q <= empty ? tsbrf_pkg::STATUS_FAIL : tsbrf_pkg::STATUS_OK;
        end else begin
          res_status_q <= (cap_en_q && fits) ? tsbrf_pkg::STATUS_OK
                                             : tsbrf_pkg::STATUS_FAIL;
        end
      end
      tsbrf_pkg::ST_STAMP: begin
        stamp_q <= prod[TW-1:0];
        cnt_q   <= '0;
      end
      tsbrf_pkg::ST_WRITE:     cnt_q <= cnt_q + NW'(1);
      tsbrf_pkg::ST_READ_WAIT: begin
        res_byte_q <= mem_rdata.data;
        res_time_q <= mem_rdata.stamp;
      end
      tsbrf_pkg::ST_DONE: begin
        if (out_free) begin
          m_status_q <= res_status_q;
          m_byte_q   <= res_byte_q;
          m_time_q   <= res_time_q;
          m_ovf_q    <= ovf_q;
        end
      end
      tsbrf_pkg::ST_IDLE: ;
      default: ;
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {7'b0, m_ovf_q, m_time_q, m_byte_q};

  // -------------------------------------------------------------- assertions
  // off the same lap the writer is always strictly behind the reader
  a_lap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !same_lap_q |-> (wp_q < rp_q))
    else $error("write pointer caught up with read pointer across a lap");

  // a failed result never carries data
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q == tsbrf_pkg::STATUS_FAIL)
      |-> (m_byte_q == '0 && m_time_q == '0))
    else $error("refused or empty result carries data");

  // overflow flag only moves on the check of a push
  a_ovf_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ovf_q) |-> $past(state_q == tsbrf_pkg::ST_CHECK && op_q == tsbrf_pkg::OP_PUSH))
    else $error("overflow flag changed outside a push check");

  // read data is only consumed after a read was issued
  a_read_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsbrf_pkg::ST_READ_WAIT) |-> $past(mem_re))
    else $error("read wait without memory read");

  // pointers move only while busy with an item
  a_ptr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsbrf_pkg::ST_IDLE) |=> ($stable(wp_q) && $stable(rp_q)))
    else $error("pointer moved while idle");

endmodule

`default_nettype wire

// ===== sim/tb_timestamped_byte_ring_fifo_top.sv =====
`default_nettype none

module tb_timestamped_byte_ring_fifo_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BYTE_W      = tsbrf_pkg::BYTE_W;
  localparam int unsigned TIME_W      = tsbrf_pkg::TIME_W;
  localparam int unsigned COUNT_W     = tsbrf_pkg::COUNT_W;
  localparam int unsigned SCALE_W     = tsbrf_pkg::SCALE_W;
  localparam int unsigned CFG_W       = tsbrf_pkg::CFG_W;
  localparam int unsigned IN_TDATA_W  = tsbrf_pkg::IN_TDATA_W;
  localparam int unsigned OUT_TDATA_W = tsbrf_pkg::OUT_TDATA_W;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned PKT_MAX = 4;
  localparam int unsigned IN_USED = COUNT_W + 4 * BYTE_W + TIME_W;

  typedef struct packed {
    logic [TIME_W-1:0]        ticks;
    logic [3:0][BYTE_W-1:0]   pkt;    // pkt[0] is the first byte
    logic [COUNT_W-1:0]       count;
    tsbrf_pkg::op_e           op;
  } ring_item_t;

  typedef struct packed {
    tsbrf_pkg::status_e  status;
    logic                ovf;
    logic [TIME_W-1:0]   stamp;
    logic [BYTE_W-1:0]   data;
  } ring_result_t;

  typedef enum logic {
    STEP_ITEM,
    STEP_CFG
  } step_kind_e;

  typedef struct {
    step_kind_e           kind;
    tsbrf_pkg::cfg_idx_e  idx;
    logic [CFG_W-1:0]     val;
    ring_item_t           item;
    bit                   typed;
    ring_result_t         want;
  } dir_step_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic                    cfg_idx_i     = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    s_axis_tuser  = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;

  timestamped_byte_ring_fifo_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // mirror of the ring and its registers
  logic [BYTE_W-1:0]   ring_bytes  [DEPTH];
  logic [TIME_W-1:0]   ring_stamps [DEPTH];
  int unsigned         wr_ptr      = 0;
  int unsigned         rd_ptr      = 0;
  bit                  lap_same    = 1'b1;
  bit                  ovf_seen    = 1'b0;
  bit                  cap_en      = 1'b1;
  logic [SCALE_W-1:0]  scale       = SCALE_W'(1);

  ring_result_t results_due[$];

  int tx_idle_pct = 38;
  int rx_idle_pct = 46;
  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int overflow_refusals = 0;
  int empty_pulls = 0;
  int unsigned peak_fill = 0;

  function automatic ring_result_t ring_apply(ring_item_t it);
    ring_result_t r;
    int unsigned n;
    int unsigned t;
    int unsigned fill;
    logic [TIME_W-1:0] stamp;
    bit fits;
    r = '{status: tsbrf_pkg::STATUS_OK, ovf: 1'b0, stamp: '0, data: '0};
    if (it.op == tsbrf_pkg::OP_PUSH) begin
      n = (32'(it.count) > PKT_MAX) ? PKT_MAX : 32'(it.count);
      t = wr_ptr + n;
      // packet must not run into the read pointer, counting the lap
      if (t >= DEPTH) begin
        fits = lap_same && (t - DEPTH < rd_ptr);
      end else begin
        fits = lap_same || (t < rd_ptr);
      end
      if (!cap_en) begin
        r.status = tsbrf_pkg::STATUS_FAIL;
      end else if (!fits) begin
        ovf_seen = 1'b1;
        r.status = tsbrf_pkg::STATUS_FAIL;
        overflow_refusals++;
      end else begin
        stamp = it.ticks * scale;
        ovf_seen = 1'b0;
        for (int i = 0; i < n; i++) begin
          ring_bytes[wr_ptr[PTR_W-1:0]] = it.pkt[i[1:0]];
          ring_stamps[wr_ptr[PTR_W-1:0]] = stamp;
          wr_ptr++;
          if (wr_ptr == DEPTH) begin
            wr_ptr = 0;
            lap_same = 1'b0;
          end
        end
      end
    end else begin
      if (lap_same && rd_ptr >= wr_ptr) begin
        r.status = tsbrf_pkg::STATUS_FAIL;
        empty_pulls++;
      end else begin
        r.data = ring_bytes[rd_ptr[PTR_W-1:0]];
        r.stamp = ring_stamps[rd_ptr[PTR_W-1:0]];
        rd_ptr++;
        if (rd_ptr == DEPTH) begin
          rd_ptr = 0;
          lap_same = 1'b1;
        end
      end
    end
    r.ovf = ovf_seen;
    fill = lap_same ? wr_ptr - rd_ptr : wr_ptr + DEPTH - rd_ptr;
    if (fill > peak_fill) peak_fill = fill;
    return r;
  endfunction

  function automatic dir_step_t dir_item(tsbrf_pkg::op_e op, logic [COUNT_W-1:0] cnt,
                                         logic [31:0] pkt, logic [TIME_W-1:0] ticks,
                                         bit typed = 1'b0,
                                         tsbrf_pkg::status_e st = tsbrf_pkg::STATUS_OK,
                                         logic ovf = 1'b0);
    dir_step_t s;
    s.kind = STEP_ITEM;
    s.idx = tsbrf_pkg::CFG_CAPTURE_ENABLE;
    s.val = '0;
    s.item = '{ticks: ticks, pkt: pkt, count: cnt, op: op};
    s.typed = typed;
    s.want = '{status: st, ovf: ovf, stamp: '0, data: '0};
    return s;
  endfunction

  function automatic dir_step_t dir_cfg(tsbrf_pkg::cfg_idx_e idx, logic [CFG_W-1:0] val);
    dir_step_t s;
    s = dir_item(tsbrf_pkg::OP_PULL, '0, '0, '0);
    s.kind = STEP_CFG;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  // hold the input side quiet until every expected result is back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(tsbrf_pkg::cfg_idx_e idx, logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == tsbrf_pkg::CFG_CAPTURE_ENABLE) cap_en = val[0];
    else scale = val[SCALE_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic drive_item(ring_item_t it, bit typed, ring_result_t want);
    ring_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W-IN_USED){1'b0}}, it.ticks, it.pkt, it.count};
    s_axis_tuser <= it.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = ring_apply(it);
    results_due.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic run_random(int n_items, int push_pct, int big_pct, int pause_every);
    ring_item_t it;
    ring_result_t none;
    none = '0;
    for (int i = 0; i < n_items; i++) begin
      it.op = ($urandom_range(99) < push_pct) ? tsbrf_pkg::OP_PUSH : tsbrf_pkg::OP_PULL;
      it.count = ($urandom_range(99) < big_pct) ? COUNT_W'($urandom_range(4, 7))
                                                : COUNT_W'($urandom_range(0, 3));
      it.pkt = $urandom;
      it.ticks = $urandom;
      drive_item(it, 1'b0, none);
      if (pause_every != 0 && (i + 1) % pause_every == 0) wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    ring_result_t want;
    ring_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = tsbrf_pkg::status_e'(m_axis_tuser);
      got.data = m_axis_tdata[7:0];
      got.stamp = m_axis_tdata[39:8];
      got.ovf = m_axis_tdata[40];
      results_seen++;
      if (results_due.size() == 0) begin
        $error("result transaction with nothing expected: tdata %h tuser %b",
               m_axis_tdata, m_axis_tuser);
        err_count++;
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          err_count++;
        end
        if (got.data !== want.data) begin
          $error("out_byte: expected %h, got %h", want.data, got.data);
          err_count++;
        end
        if (got.stamp !== want.stamp) begin
          $error("out_time: expected %h, got %h", want.stamp, got.stamp);
          err_count++;
        end
        if (got.ovf !== want.ovf) begin
          $error("overflow_flag: expected %b, got %b", want.ovf, got.ovf);
          err_count++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("tb_timestamped_byte_ring_fifo_top: done, errors");
    $finish;
  end

  initial begin
    dir_step_t directed[$];

    // after reset: empty pulls fail, an empty packet is accepted
    directed.push_back(dir_item(tsbrf_pkg::OP_PULL, 3'd0, 32'h0, 32'h0, 1'b1,
                                tsbrf_pkg::STATUS_FAIL));
    directed.push_back(dir_item(tsbrf_pkg::OP_PUSH, 3'd0, 32'hFFFF_FFFF, 32'h0, 1'b1,
                                tsbrf_pkg::STATUS_OK));
    directed.push_back(dir_item(tsbrf_pkg::OP_PULL, 3'd0, 32'h0, 32'h0, 1'b1,
                                tsbrf_pkg::STATUS_FAIL));
    directed.push_back(dir_item(tsbrf_pkg::OP_PUSH, 3'd4, 32'h5AA5_FF00, 32'hFFFF_FFFF));
    repeat (4) directed.push_back(dir_item(tsbrf_pkg::OP_PULL, 3'd0, 32'h0, 32'h0));
    directed.push_back(dir_item(tsbrf_pkg::OP_PULL, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                1'b1, tsbrf_pkg::STATUS_FAIL));
    // scale 1000, oversized count, stamp truncation
    directed.push_back(dir_cfg(tsbrf_pkg::CFG_TICK_SCALE, 10'd1000));
    directed.push_back(dir_item(tsbrf_pkg::OP_PUSH, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    directed.push_back(dir_item(tsbrf_pkg::OP_PUSH, 3'd3, 32'h0012_3456, 32'd12345));
    // scale zero gives zero stamps
    directed.push_back(dir_cfg(tsbrf_pkg::CFG_TICK_SCALE, 10'd0));
    directed.push_back(dir_item(tsbrf_pkg::OP_PUSH, 3'd1, 32'h0000_00AB, 32'hFFFF_FFFF));
    // capture off: push refused without touching overflow, pulls still work
    directed.push_back(dir_cfg(tsbrf_pkg::CFG_CAPTURE_ENABLE, 10'd0));
    directed.push_back(dir_item(tsbrf_pkg::OP_PUSH, 3'd4, 32'h1234_5678, 32'h8000_0000,
                                1'b1, tsbrf_pkg::STATUS_FAIL));
    directed.push_back(dir_item(tsbrf_pkg::OP_PULL, 3'd0, 32'h0, 32'h0));
    directed.push_back(dir_cfg(tsbrf_pkg::CFG_CAPTURE_ENABLE, 10'd1));
    directed.push_back(dir_cfg(tsbrf_pkg::CFG_TICK_SCALE, 10'd1));
    repeat (7) directed.push_back(dir_item(tsbrf_pkg::OP_PULL, 3'd0, 32'h0, 32'h0));
    directed.push_back(dir_item(tsbrf_pkg::OP_PULL, 3'd0, 32'h0, 32'h0, 1'b1,
                                tsbrf_pkg::STATUS_FAIL));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      if (directed[i].kind == STEP_CFG) begin
        write_reg(directed[i].idx, directed[i].val);
      end else begin
        drive_item(directed[i].item, directed[i].typed, directed[i].want);
      end
    end

    // fill past full so the write side wraps and overflow toggles
    write_reg(tsbrf_pkg::CFG_TICK_SCALE, CFG_W'($urandom_range(1, 1000)));
    run_random(300, 95, 90, 0);
    // capture off while overflow is likely set
    write_reg(tsbrf_pkg::CFG_CAPTURE_ENABLE, 10'd0);
    write_reg(tsbrf_pkg::CFG_TICK_SCALE, CFG_W'($urandom_range(1, 1000)));
    run_random(20, 50, 60, 0);
    write_reg(tsbrf_pkg::CFG_CAPTURE_ENABLE, 10'd1);

    // mostly pulls, idle ratios swapped
    tx_idle_pct = 46;
    rx_idle_pct = 38;
    run_random(60, 4, 0, 0);

    // back to back, mixed traffic with full pauses now and then
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(tsbrf_pkg::CFG_TICK_SCALE, 10'd1000);
    run_random(60, 50, 60, 30);
    write_reg(tsbrf_pkg::CFG_TICK_SCALE, CFG_W'($urandom_range(1, 1000)));
    run_random(60, 50, 60, 30);

    wait_drained();
    repeat (20) @(posedge clk_i);
    $display("%0d transactions in, %0d results checked, peak fill %0d of %0d bytes",
             items_sent, results_seen, peak_fill, DEPTH - 1);
    $display("%0d pushes refused on overflow, %0d pulls found the ring empty",
             overflow_refusals, empty_pulls);
    if (err_count == 0) begin
      $display("tb_timestamped_byte_ring_fifo_top: done, clean");
    end else begin
      $display("tb_timestamped_byte_ring_fifo_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
